/* hdl/assert_macros.svh */
// Assertion macros shared by the RTL; they compile to nothing under synthesis.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

/* hdl/ils_pkg.sv */
// Types, character codes and limits shared by the integer literal scanner.
package ils_pkg;

    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam logic [63:0] POS_LIMIT = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] NEG_LIMIT = 64'h7FFF_FFFF_FFFF_FFFF;

    localparam logic [7:0] CH_NUL        = 8'h00;
    localparam logic [7:0] CH_TAB        = 8'h09;
    localparam logic [7:0] CH_LF         = 8'h0A;
    localparam logic [7:0] CH_CR         = 8'h0D;
    localparam logic [7:0] CH_SPACE      = 8'h20;
    localparam logic [7:0] CH_HASH       = 8'h23;
    localparam logic [7:0] CH_PLUS       = 8'h2B;
    localparam logic [7:0] CH_COMMA      = 8'h2C;
    localparam logic [7:0] CH_MINUS      = 8'h2D;
    localparam logic [7:0] CH_DOT        = 8'h2E;
    localparam logic [7:0] CH_ZERO       = 8'h30;
    localparam logic [7:0] CH_NINE       = 8'h39;
    localparam logic [7:0] CH_COLON      = 8'h3A;
    localparam logic [7:0] CH_UPPER_A    = 8'h41;
    localparam logic [7:0] CH_UPPER_E    = 8'h45;
    localparam logic [7:0] CH_UPPER_F    = 8'h46;
    localparam logic [7:0] CH_UPPER_T    = 8'h54;
    localparam logic [7:0] CH_RBRACKET   = 8'h5D;
    localparam logic [7:0] CH_UNDERSCORE = 8'h5F;
    localparam logic [7:0] CH_LOWER_A    = 8'h61;
    localparam logic [7:0] CH_LOWER_B    = 8'h62;
    localparam logic [7:0] CH_LOWER_E    = 8'h65;
    localparam logic [7:0] CH_LOWER_F    = 8'h66;
    localparam logic [7:0] CH_LOWER_I    = 8'h69;
    localparam logic [7:0] CH_LOWER_N    = 8'h6E;
    localparam logic [7:0] CH_LOWER_O    = 8'h6F;
    localparam logic [7:0] CH_LOWER_X    = 8'h78;
    localparam logic [7:0] CH_RBRACE     = 8'h7D;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_ERR   = 2'd1,
        ST_OTHER = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        RADIX_DEC = 2'd0,
        RADIX_HEX = 2'd1,
        RADIX_BIN = 2'd2,
        RADIX_OCT = 2'd3
    } radix_t;

    // One classified character word as it travels from front to back.
    typedef struct packed {
        logic [7:0] ch;
        logic       start;
        logic       eoi;
        logic [3:0] digit;
        logic       dec_digit;
        logic       hex_digit;
        logic       underscore;
        logic       term;
        logic       float_mark;
        logic       dt_mark;
        logic       minus;
        logic       plus;
    } char_entry_t;

    typedef struct packed {
        status_t     status;
        logic        is_negative;
        logic [63:0] magnitude;
        radix_t      radix;
        logic        overflowed;
    } result_t;

endpackage

/* hdl/ils_front.sv */
// Front end: accepts character words and classifies them for the back end.
module ils_front
    import ils_pkg::*;
(
    input  logic        char_valid,
    output logic        char_stall,
    input  logic [7:0]  ch,
    input  logic        start_req,
    input  logic        end_of_input,
    input  logic        queue_full,
    output logic        push_valid,
    output char_entry_t push_entry
);

    assign char_stall = queue_full;
    assign push_valid = char_valid && !queue_full;

    always_comb
    begin
        push_entry            = '0;
        push_entry.ch         = ch;
        push_entry.start      = start_req;
        push_entry.eoi        = end_of_input;
        push_entry.dec_digit  = (ch >= CH_ZERO) && (ch <= CH_NINE);
        push_entry.underscore = (ch == CH_UNDERSCORE);
        push_entry.term       = (ch == CH_SPACE) || (ch == CH_TAB) || (ch == CH_CR)
                             || (ch == CH_LF) || (ch == CH_HASH) || (ch == CH_COMMA)
                             || (ch == CH_RBRACKET) || (ch == CH_RBRACE);
        push_entry.float_mark = (ch == CH_DOT) || (ch == CH_LOWER_E) || (ch == CH_UPPER_E);
        push_entry.dt_mark    = (ch == CH_UPPER_T) || (ch == CH_COLON);
        push_entry.minus      = (ch == CH_MINUS);
        push_entry.plus       = (ch == CH_PLUS);

        if ((ch >= CH_ZERO) && (ch <= CH_NINE))
        begin
            push_entry.hex_digit = 1'b1;
            push_entry.digit     = 4'(ch - CH_ZERO);
        end
        else if ((ch >= CH_LOWER_A) && (ch <= CH_LOWER_F))
        begin
            push_entry.hex_digit = 1'b1;
            push_entry.digit     = 4'(ch - CH_LOWER_A + 8'd10);
        end
        else if ((ch >= CH_UPPER_A) && (ch <= CH_UPPER_F))
        begin
            push_entry.hex_digit = 1'b1;
            push_entry.digit     = 4'(ch - CH_UPPER_A + 8'd10);
        end
    end

endmodule

/* hdl/ils_queue.sv */
// Short word queue that decouples the front end from the back end.
module ils_queue
    import ils_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        push_valid,
    input  char_entry_t push_entry,
    output logic        full,
    input  logic        pop,
    output logic        pop_valid,
    output char_entry_t pop_entry
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    char_entry_t      slots [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign full      = (count_reg == FULL_CNT);
    assign pop_valid = (count_reg != '0);
    assign pop_entry = slots[rd_ptr_reg];
    assign do_push   = push_valid && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_PTR) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_PTR) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

/* hdl/ils_back.sv */
// Back end: literal state machine, saturating accumulator and result register.
module ils_back
    import ils_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        entry_valid,
    input  char_entry_t entry,
    output logic        entry_pop,
    output logic        result_valid,
    input  logic        result_stall,
    output result_t     result
);

    typedef enum logic [3:0] {
        PH_IDLE,
        PH_SIGN_START,
        PH_ZERO_START,
        PH_DEC_U,
        PH_FAIL_U,
        PH_DEC_S,
        PH_FAIL_S,
        PH_PREFIXED,
        PH_INF,
        PH_NAN
    } phase_t;

    typedef struct packed {
        logic [63:0] acc;
        logic        sat;
    } acc_upd_t;

    function automatic acc_upd_t accumulate(input logic [63:0] acc, input logic sat,
                                            input logic neg, input radix_t radix,
                                            input logic [3:0] d);
        logic [67:0] scaled;
        logic [67:0] sum;
        logic [63:0] lim;
        acc_upd_t    r;
        lim = neg ? NEG_LIMIT : POS_LIMIT;
        case (radix)
            RADIX_HEX: scaled = {acc, 4'b0};
            RADIX_BIN: scaled = {3'b0, acc, 1'b0};
            RADIX_OCT: scaled = {1'b0, acc, 3'b0};
            default:   scaled = {1'b0, acc, 3'b0} + {3'b0, acc, 1'b0};
        endcase
        sum = scaled + {64'b0, d};
        // acc * radix + d > limit is the same test as acc > (limit - d) / radix.
        if (sat || (sum > {4'b0, lim}))
        begin
            r.acc = lim;
            r.sat = 1'b1;
        end
        else
        begin
            r.acc = sum[63:0];
            r.sat = 1'b0;
        end
        return r;
    endfunction

    function automatic logic [7:0] word_letter(input logic is_nan, input logic [1:0] idx);
        logic [7:0] c;
        case (idx)
            2'd0:    c = is_nan ? CH_LOWER_N : CH_LOWER_I;
            2'd1:    c = is_nan ? CH_LOWER_A : CH_LOWER_N;
            2'd2:    c = is_nan ? CH_LOWER_N : CH_LOWER_F;
            default: c = CH_NUL;
        endcase
        return c;
    endfunction

    phase_t      phase_reg, phase_next, base_phase;
    logic [63:0] acc_reg, acc_next, base_acc;
    logic        sign_reg, sign_next, base_sign;
    radix_t      radix_reg, radix_next, base_radix;
    logic        need_reg, need_next, base_need;
    logic        lz_reg, lz_next, base_lz;
    logic [1:0]  dc_reg, dc_next, base_dc;
    logic [1:0]  mc_reg, mc_next, base_mc;
    logic        sat_reg, sat_next, base_sat;

    acc_upd_t    upd;
    logic        emit;
    status_t     emit_status;
    logic        run_dec;
    logic        dec_signed;
    phase_t      ok_ph, fail_ph;
    logic        slot_free;
    logic        advance;
    logic        result_valid_reg, result_valid_next;
    result_t     result_reg;

    assign slot_free = !result_valid_reg || !result_stall;
    assign advance   = entry_valid && slot_free;
    assign entry_pop = advance;

    // A start word clears the literal state before the character is applied.
    always_comb
    begin
        if (entry.start)
        begin
            base_phase = PH_IDLE;
            base_acc   = '0;
            base_sign  = 1'b0;
            base_radix = RADIX_DEC;
            base_need  = 1'b1;
            base_lz    = 1'b0;
            base_dc    = '0;
            base_mc    = '0;
            base_sat   = 1'b0;
        end
        else
        begin
            base_phase = phase_reg;
            base_acc   = acc_reg;
            base_sign  = sign_reg;
            base_radix = radix_reg;
            base_need  = need_reg;
            base_lz    = lz_reg;
            base_dc    = dc_reg;
            base_mc    = mc_reg;
            base_sat   = sat_reg;
        end
    end

    assign upd = accumulate(base_acc, base_sat, base_sign, base_radix, entry.digit);

    always_comb
    begin
        phase_next  = base_phase;
        acc_next    = base_acc;
        sign_next   = base_sign;
        radix_next  = base_radix;
        need_next   = base_need;
        lz_next     = base_lz;
        dc_next     = base_dc;
        mc_next     = base_mc;
        sat_next    = base_sat;
        emit        = 1'b0;
        emit_status = ST_OK;
        run_dec     = 1'b0;
        dec_signed  = 1'b0;

        if (entry.eoi)
        begin
            if (entry.start || (phase_reg != PH_IDLE))
            begin
                emit        = 1'b1;
                emit_status = ST_ERR;
            end
        end
        else if (entry.start)
        begin
            if (entry.plus || entry.minus)
            begin
                sign_next  = entry.minus;
                phase_next = PH_SIGN_START;
            end
            else if (entry.ch == CH_ZERO)
            begin
                lz_next    = 1'b1;
                dc_next    = 2'd1;
                acc_next   = upd.acc;
                sat_next   = upd.sat;
                need_next  = 1'b0;
                phase_next = PH_ZERO_START;
            end
            else if ((entry.ch == CH_LOWER_I) || (entry.ch == CH_LOWER_N))
            begin
                phase_next = (entry.ch == CH_LOWER_I) ? PH_INF : PH_NAN;
                dc_next    = 2'd1;
            end
            else
            begin
                phase_next = PH_DEC_U;
                run_dec    = 1'b1;
            end
        end
        else
        begin
            case (phase_reg)
                PH_SIGN_START:
                begin
                    if ((entry.ch == CH_LOWER_I) || (entry.ch == CH_LOWER_N))
                    begin
                        phase_next = (entry.ch == CH_LOWER_I) ? PH_INF : PH_NAN;
                        dc_next    = 2'd1;
                    end
                    else
                    begin
                        phase_next = PH_DEC_S;
                        run_dec    = 1'b1;
                        dec_signed = 1'b1;
                    end
                end
                PH_ZERO_START:
                begin
                    if (entry.ch == CH_LOWER_X || entry.ch == CH_LOWER_B
                        || entry.ch == CH_LOWER_O)
                    begin
                        radix_next = (entry.ch == CH_LOWER_X) ? RADIX_HEX :
                                     (entry.ch == CH_LOWER_B) ? RADIX_BIN : RADIX_OCT;
                        acc_next   = '0;
                        lz_next    = 1'b0;
                        need_next  = 1'b1;
                        phase_next = PH_PREFIXED;
                    end
                    else
                    begin
                        phase_next = PH_DEC_U;
                        run_dec    = 1'b1;
                    end
                end
                PH_DEC_U, PH_FAIL_U:
                begin
                    run_dec = 1'b1;
                end
                PH_DEC_S, PH_FAIL_S:
                begin
                    run_dec    = 1'b1;
                    dec_signed = 1'b1;
                end
                PH_PREFIXED:
                begin
                    if (entry.hex_digit)
                    begin
                        if (((radix_reg == RADIX_BIN) && (entry.digit >= 4'd2))
                            || ((radix_reg != RADIX_BIN) && (radix_reg != RADIX_HEX)
                                && (entry.digit >= 4'd8)))
                        begin
                            emit        = 1'b1;
                            emit_status = ST_ERR;
                        end
                        else
                        begin
                            acc_next  = upd.acc;
                            sat_next  = upd.sat;
                            need_next = 1'b0;
                        end
                    end
                    else if (entry.underscore)
                    begin
                        if (need_reg)
                        begin
                            emit        = 1'b1;
                            emit_status = ST_ERR;
                        end
                        need_next = 1'b1;
                    end
                    else
                    begin
                        emit        = 1'b1;
                        emit_status = (entry.term && !need_reg) ? ST_OK : ST_ERR;
                    end
                end
                PH_INF, PH_NAN:
                begin
                    if ((dc_reg == 2'd3)
                        || (entry.ch != word_letter(phase_reg == PH_NAN, dc_reg)))
                    begin
                        emit        = 1'b1;
                        emit_status = ST_ERR;
                    end
                    else
                    begin
                        dc_next = dc_reg + 2'd1;
                        if (dc_reg == 2'd2)
                        begin
                            emit        = 1'b1;
                            emit_status = ST_OTHER;
                        end
                    end
                end
                default:
                begin
                    phase_next = PH_IDLE;
                end
            endcase
        end

        // Decimal body, shared by the unsigned and the signed paths.
        ok_ph   = dec_signed ? PH_DEC_S : PH_DEC_U;
        fail_ph = dec_signed ? PH_FAIL_S : PH_FAIL_U;
        if (run_dec)
        begin
            if (entry.dec_digit)
            begin
                if (phase_next == ok_ph)
                begin
                    if (base_lz)
                    begin
                        phase_next = fail_ph;
                    end
                    else
                    begin
                        if ((base_dc == 2'd0) && (entry.digit == 4'd0))
                        begin
                            lz_next = 1'b1;
                        end
                        if (base_dc != 2'd3)
                        begin
                            dc_next = base_dc + 2'd1;
                        end
                        acc_next  = upd.acc;
                        sat_next  = upd.sat;
                        need_next = 1'b0;
                    end
                end
            end
            else if (entry.underscore)
            begin
                if (phase_next == ok_ph)
                begin
                    if (base_need)
                    begin
                        phase_next = fail_ph;
                    end
                    need_next = 1'b1;
                end
            end
            else if (entry.float_mark)
            begin
                emit        = 1'b1;
                emit_status = ST_OTHER;
            end
            else if (entry.term)
            begin
                emit        = 1'b1;
                emit_status = ((phase_next == ok_ph) && !base_need) ? ST_OK : ST_ERR;
            end
            else if (dec_signed)
            begin
                phase_next = fail_ph;
            end
            else if (entry.dt_mark)
            begin
                emit        = 1'b1;
                emit_status = ST_OTHER;
            end
            else if (entry.minus)
            begin
                if (base_mc != 2'd3)
                begin
                    mc_next = base_mc + 2'd1;
                end
                // A second minus sign marks a date, which is not an integer.
                if (base_mc != 2'd0)
                begin
                    emit        = 1'b1;
                    emit_status = ST_OTHER;
                end
                else
                begin
                    phase_next = fail_ph;
                end
            end
            else if (entry.plus)
            begin
                phase_next = fail_ph;
            end
            else
            begin
                emit        = 1'b1;
                emit_status = ST_ERR;
            end
        end

        if (emit)
        begin
            phase_next = PH_IDLE;
        end
    end

    always_comb
    begin
        result_valid_next = result_valid_reg;
        if (advance && emit)
        begin
            result_valid_next = 1'b1;
        end
        else if (result_valid_reg && !result_stall)
        begin
            result_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg        <= PH_IDLE;
            acc_reg          <= '0;
            sign_reg         <= 1'b0;
            radix_reg        <= RADIX_DEC;
            need_reg         <= 1'b1;
            lz_reg           <= 1'b0;
            dc_reg           <= '0;
            mc_reg           <= '0;
            sat_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
            result_reg       <= '0;
        end
        else
        begin
            result_valid_reg <= result_valid_next;
            if (advance)
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                sign_reg  <= sign_next;
                radix_reg <= radix_next;
                need_reg  <= need_next;
                lz_reg    <= lz_next;
                dc_reg    <= dc_next;
                mc_reg    <= mc_next;
                sat_reg   <= sat_next;
            end
            if (advance && emit)
            begin
                result_reg.status      <= emit_status;
                result_reg.is_negative <= sign_next;
                result_reg.magnitude   <= (emit_status == ST_OK) ? acc_next : '0;
                result_reg.radix       <= radix_next;
                result_reg.overflowed  <= (emit_status == ST_OK) ? sat_next : 1'b0;
            end
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

/* hdl/integer_literal_scanner.sv */
// Integer literal scanner: one character word per cycle in while char_stall is low, one
// classification per literal out. The front end classifies each accepted character and
// writes it into a queue of QUEUE_DEPTH words; the back end takes one word per cycle when
// its result slot is free, runs the literal state machine and the saturating multiply-add
// accumulator, and loads a result register. With no stall the sustained rate is one
// character per cycle, set by the accumulate step in the back end. A terminating character
// passes through the queue and the result register before its result is on the result
// port; while stalled there, the queue takes characters until it holds QUEUE_DEPTH words.
`include "assert_macros.svh"

module integer_literal_scanner
    import ils_pkg::*;
#(
    parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEFAULT
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    output logic        char_stall,
    input  logic [7:0]  ch,
    input  logic        start_req,
    input  logic        end_of_input,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [1:0]  status,
    output logic        is_negative,
    output logic [63:0] magnitude,
    output logic [1:0]  radix_code,
    output logic        overflowed
);

    logic        push_valid;
    char_entry_t push_entry;
    logic        queue_full;
    logic        entry_pop;
    logic        entry_valid;
    char_entry_t entry;
    result_t     result;

    ils_front u_front (
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .ch           (ch),
        .start_req    (start_req),
        .end_of_input (end_of_input),
        .queue_full   (queue_full),
        .push_valid   (push_valid),
        .push_entry   (push_entry)
    );

    ils_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_entry (push_entry),
        .full       (queue_full),
        .pop        (entry_pop),
        .pop_valid  (entry_valid),
        .pop_entry  (entry)
    );

    ils_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .entry_valid  (entry_valid),
        .entry        (entry),
        .entry_pop    (entry_pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    assign status      = result.status;
    assign is_negative = result.is_negative;
    assign magnitude   = result.magnitude;
    assign radix_code  = result.radix;
    assign overflowed  = result.overflowed;

    // Only an integer carries a value or an overflow mark.
    `ASSERT_IMPLIES(a_value_only_when_ok, clk, rst_n,
        result_valid && (status != ST_OK), (magnitude == '0) && !overflowed)

    // A clamped value sits exactly at the limit for its sign.
    `ASSERT_IMPLIES(a_clamp_at_limit, clk, rst_n,
        result_valid && overflowed,
        (is_negative && (magnitude == NEG_LIMIT)) || (!is_negative && (magnitude == POS_LIMIT)))

    // Prefixes are only reached from a bare leading zero, never after a sign.
    `ASSERT_IMPLIES(a_prefix_unsigned, clk, rst_n,
        result_valid && (radix_code != RADIX_DEC), !is_negative)

    // A negative integer never exceeds the signed magnitude limit.
    `ASSERT_IMPLIES(a_negative_range, clk, rst_n,
        result_valid && is_negative && (status == ST_OK), magnitude <= NEG_LIMIT)

endmodule

/* sim/ils_checker.sv */
// Checker for the integer literal scanner: predicts each literal's classification and compares.
`timescale 1ns / 100ps

module ils_checker
    import ils_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        char_valid,
    input  logic        char_stall,
    input  logic [7:0]  ch,
    input  logic        start_req,
    input  logic        end_of_input,
    input  logic        result_valid,
    input  logic        result_stall,
    input  logic [1:0]  status,
    input  logic        is_negative,
    input  logic [63:0] magnitude,
    input  logic [1:0]  radix_code,
    input  logic        overflowed,
    output int          fail_count,
    output int          pending
);

    typedef enum logic [3:0] {
        LIT_IDLE,
        LIT_SIGN,
        LIT_ZERO,
        LIT_DEC,
        LIT_DEC_BAD,
        LIT_SDEC,
        LIT_SDEC_BAD,
        LIT_PREFIXED,
        LIT_INF,
        LIT_NAN
    } lit_phase_t;

    lit_phase_t  lit_phase;
    logic [63:0] value_acc;
    logic        lit_negative;
    radix_t      lit_radix;
    logic        awaiting_digit;
    logic        saw_leading_zero;
    logic [1:0]  digit_tally;
    logic [1:0]  minus_tally;
    logic        clamped;

    result_t     classified[$];
    int          mismatches = 0;

    task automatic flag_mismatch(input string what);
        $display("%0t ils_checker: %s", $time, what);
        mismatches++;
    endtask

    function automatic void clear_literal();
        lit_phase        = LIT_IDLE;
        value_acc        = '0;
        lit_negative     = 1'b0;
        lit_radix        = RADIX_DEC;
        awaiting_digit   = 1'b1;
        saw_leading_zero = 1'b0;
        digit_tally      = 2'd0;
        minus_tally      = 2'd0;
        clamped          = 1'b0;
    endfunction

    function automatic void close_literal(input status_t st);
        result_t r;
        r.status      = st;
        r.is_negative = lit_negative;
        r.magnitude   = (st == ST_OK) ? value_acc : 64'd0;
        r.radix       = lit_radix;
        r.overflowed  = (st == ST_OK) && clamped;
        classified.push_back(r);
        lit_phase = LIT_IDLE;
    endfunction

    function automatic logic is_terminator(input logic [7:0] c);
        return c == CH_SPACE || c == CH_TAB || c == CH_CR || c == CH_LF ||
               c == CH_HASH || c == CH_COMMA || c == CH_RBRACKET || c == CH_RBRACE;
    endfunction

    function automatic logic [63:0] radix_base();
        case (lit_radix)
            RADIX_HEX: return 64'd16;
            RADIX_BIN: return 64'd2;
            RADIX_OCT: return 64'd8;
            default:   return 64'd10;
        endcase
    endfunction

    // Multiply-add with a clamp at the limit for the sign; once clamped it stays there.
    function automatic void add_digit(input logic [3:0] d);
        logic [63:0] base;
        logic [63:0] ceiling;
        base    = radix_base();
        ceiling = lit_negative ? NEG_LIMIT : POS_LIMIT;
        if (clamped || value_acc > (ceiling - {60'd0, d}) / base)
        begin
            value_acc = ceiling;
            clamped   = 1'b1;
        end
        else
            value_acc = value_acc * base + {60'd0, d};
        awaiting_digit = 1'b0;
    endfunction

    function automatic bit take_decimal(input logic [3:0] d);
        if (saw_leading_zero)
            return 1'b0;
        if (digit_tally == 2'd0 && d == 4'd0)
            saw_leading_zero = 1'b1;
        if (digit_tally < 2'd3)
            digit_tally = digit_tally + 2'd1;
        add_digit(d);
        return 1'b1;
    endfunction

    function automatic void decimal_char(input logic [7:0] c, input bit signed_path);
        lit_phase_t ok_ph;
        lit_phase_t bad_ph;
        logic [3:0] d;
        ok_ph  = signed_path ? LIT_SDEC : LIT_DEC;
        bad_ph = signed_path ? LIT_SDEC_BAD : LIT_DEC_BAD;
        d      = 4'(c - CH_ZERO);
        if (c >= CH_ZERO && c <= CH_NINE)
        begin
            if (lit_phase == ok_ph && !take_decimal(d))
                lit_phase = bad_ph;
        end
        else if (c == CH_UNDERSCORE)
        begin
            if (lit_phase == ok_ph)
            begin
                if (awaiting_digit)
                    lit_phase = bad_ph;
                awaiting_digit = 1'b1;
            end
        end
        else if (c == CH_DOT || c == CH_LOWER_E || c == CH_UPPER_E)
            close_literal(ST_OTHER);
        else if (is_terminator(c))
            close_literal((lit_phase == ok_ph && !awaiting_digit) ? ST_OK : ST_ERR);
        else if (signed_path)
            lit_phase = bad_ph;
        else if (c == CH_UPPER_T || c == CH_COLON)
            close_literal(ST_OTHER);
        else if (c == CH_MINUS)
        begin
            // A lone minus inside an unsigned number may still turn out to be a date.
            if (minus_tally < 2'd3)
                minus_tally = minus_tally + 2'd1;
            if (minus_tally >= 2'd2)
                close_literal(ST_OTHER);
            else
                lit_phase = bad_ph;
        end
        else if (c == CH_PLUS)
            lit_phase = bad_ph;
        else
            close_literal(ST_ERR);
    endfunction

    function automatic void prefixed_char(input logic [7:0] c);
        int dval;
        dval = -1;
        if (c >= CH_ZERO && c <= CH_NINE)
            dval = int'(c - CH_ZERO);
        else if (c >= CH_LOWER_A && c <= CH_LOWER_F)
            dval = c - CH_LOWER_A + 10;
        else if (c >= CH_UPPER_A && c <= CH_UPPER_F)
            dval = c - CH_UPPER_A + 10;
        if (dval >= 0)
        begin
            if (dval >= radix_base())
                close_literal(ST_ERR);
            else
                add_digit(dval[3:0]);
        end
        else if (c == CH_UNDERSCORE)
        begin
            if (awaiting_digit)
                close_literal(ST_ERR);
            else
                awaiting_digit = 1'b1;
        end
        else if (is_terminator(c))
            close_literal(awaiting_digit ? ST_ERR : ST_OK);
        else
            close_literal(ST_ERR);
    endfunction

    function automatic logic [7:0] word_letter(input logic [1:0] i);
        if (lit_phase == LIT_INF)
            return (i == 2'd0) ? CH_LOWER_I : (i == 2'd1) ? CH_LOWER_N : CH_LOWER_F;
        return (i == 2'd1) ? CH_LOWER_A : CH_LOWER_N;
    endfunction

    // While spelling inf or nan, digit_tally holds the index of the next letter.
    function automatic void word_char(input logic [7:0] c);
        if (digit_tally == 2'd3 || c != word_letter(digit_tally))
            close_literal(ST_ERR);
        else
        begin
            digit_tally = digit_tally + 2'd1;
            if (digit_tally == 2'd3)
                close_literal(ST_OTHER);
        end
    endfunction

    function automatic void first_char(input logic [7:0] c);
        if (c == CH_PLUS || c == CH_MINUS)
        begin
            lit_negative = (c == CH_MINUS);
            lit_phase    = LIT_SIGN;
        end
        else if (c == CH_ZERO)
        begin
            void'(take_decimal(4'd0));
            lit_phase = LIT_ZERO;
        end
        else if (c == CH_LOWER_I || c == CH_LOWER_N)
        begin
            lit_phase   = (c == CH_LOWER_I) ? LIT_INF : LIT_NAN;
            digit_tally = 2'd1;
        end
        else
        begin
            lit_phase = LIT_DEC;
            decimal_char(c, 1'b0);
        end
    endfunction

    function automatic void scan_word(input logic [7:0] c, input logic start, input logic eoi);
        if (start)
            clear_literal();
        if (eoi)
        begin
            if (start || lit_phase != LIT_IDLE)
                close_literal(ST_ERR);
        end
        else if (start)
            first_char(c);
        else
        begin
            case (lit_phase)
                LIT_SIGN:
                    if (c == CH_LOWER_I || c == CH_LOWER_N)
                    begin
                        lit_phase   = (c == CH_LOWER_I) ? LIT_INF : LIT_NAN;
                        digit_tally = 2'd1;
                    end
                    else
                    begin
                        lit_phase = LIT_SDEC;
                        decimal_char(c, 1'b1);
                    end
                LIT_ZERO:
                    if (c == CH_LOWER_X || c == CH_LOWER_B || c == CH_LOWER_O)
                    begin
                        lit_radix = (c == CH_LOWER_X) ? RADIX_HEX :
                                    (c == CH_LOWER_B) ? RADIX_BIN : RADIX_OCT;
                        value_acc        = '0;
                        saw_leading_zero = 1'b0;
                        awaiting_digit   = 1'b1;
                        lit_phase        = LIT_PREFIXED;
                    end
                    else
                    begin
                        lit_phase = LIT_DEC;
                        decimal_char(c, 1'b0);
                    end
                LIT_DEC, LIT_DEC_BAD:   decimal_char(c, 1'b0);
                LIT_SDEC, LIT_SDEC_BAD: decimal_char(c, 1'b1);
                LIT_PREFIXED:           prefixed_char(c);
                LIT_INF, LIT_NAN:       word_char(c);
                default:                lit_phase = LIT_IDLE;
            endcase
        end
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        result_t want;
        if (!rst_n)
        begin
            clear_literal();
            classified.delete();
            mismatches = 0;
            fail_count <= 0;
            pending    <= 0;
        end
        else
        begin
            // Results first: a word accepted at this edge cannot have produced one yet.
            if (result_valid && !result_stall)
            begin
                if (classified.size() == 0)
                    flag_mismatch($sformatf("unexpected result: status %0d magnitude %0h",
                                            status, magnitude));
                else
                begin
                    want = classified.pop_front();
                    if (status !== want.status)
                        flag_mismatch($sformatf("status %0d, expected %0d",
                                                status, want.status));
                    if (is_negative !== want.is_negative)
                        flag_mismatch($sformatf("is_negative %0b, expected %0b",
                                                is_negative, want.is_negative));
                    if (magnitude !== want.magnitude)
                        flag_mismatch($sformatf("magnitude %0h, expected %0h",
                                                magnitude, want.magnitude));
                    if (radix_code !== want.radix)
                        flag_mismatch($sformatf("radix_code %0d, expected %0d",
                                                radix_code, want.radix));
                    if (overflowed !== want.overflowed)
                        flag_mismatch($sformatf("overflowed %0b, expected %0b",
                                                overflowed, want.overflowed));
                end
            end
            if (char_valid && !char_stall)
                scan_word(ch, start_req, end_of_input);
            fail_count <= mismatches;
            pending    <= classified.size();
        end
    end

endmodule

/* sim/integer_literal_scanner_tb.sv */
// Top of the integer literal scanner testbench: clock, reset, character stimulus and verdict.
`timescale 1ns / 100ps

module integer_literal_scanner_tb
    import ils_pkg::*;
();

    localparam int HOLD_CYCLES     = 400;
    localparam int QUIET_LIMIT     = 4000;
    localparam int ITEMS_PER_PHASE = 475;
    localparam int DRAIN_CYCLES    = 4 * QUEUE_DEPTH_DEFAULT + 8;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        char_valid   = 1'b0;
    logic        char_stall;
    logic [7:0]  ch           = 8'h00;
    logic        start_req    = 1'b0;
    logic        end_of_input = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [1:0]  status;
    logic        is_negative;
    logic [63:0] magnitude;
    logic [1:0]  radix_code;
    logic        overflowed;
    int          fail_count;
    int          pending;

    int          send_idle_pct  = 0;
    int          recv_stall_pct = 0;
    bit          hold_req       = 1'b0;
    int          quiet_cycles   = 0;
    int          chars_sent     = 0;
    logic [7:0]  lit_chars[$];

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    integer_literal_scanner dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .ch           (ch),
        .start_req    (start_req),
        .end_of_input (end_of_input),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .is_negative  (is_negative),
        .magnitude    (magnitude),
        .radix_code   (radix_code),
        .overflowed   (overflowed)
    );

    ils_checker scan_check (
        .clk          (clk),
        .rst_n        (rst_n),
        .char_valid   (char_valid),
        .char_stall   (char_stall),
        .ch           (ch),
        .start_req    (start_req),
        .end_of_input (end_of_input),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .status       (status),
        .is_negative  (is_negative),
        .magnitude    (magnitude),
        .radix_code   (radix_code),
        .overflowed   (overflowed),
        .fail_count   (fail_count),
        .pending      (pending)
    );

    // Ends the run when neither channel has moved a word for too long.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((char_valid && !char_stall) || (result_valid && !result_stall))
                quiet_cycles <= 0;
            else if (quiet_cycles + 1 >= QUIET_LIMIT)
            begin
                $display("[FAIL] regression broken");
                $finish;
            end
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Result side: random stalls, plus one long hold-off on request so the input backs up.
    initial
    begin : result_sink
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                hold_req = 1'b0;
                result_stall <= 1'b1;
                for (int n = 0; n < HOLD_CYCLES; n++)
                    @(posedge clk);
            end
            else
                result_stall <= (recv_stall_pct != 0) && ($urandom_range(99, 0) < recv_stall_pct);
        end
    end

    task automatic send_word(input logic [7:0] c, input logic s, input logic e);
        while (send_idle_pct != 0 && $urandom_range(99, 0) < send_idle_pct)
        begin
            char_valid <= 1'b0;
            @(posedge clk);
        end
        char_valid   <= 1'b1;
        ch           <= c;
        start_req    <= s;
        end_of_input <= e;
        @(posedge clk);
        while (char_stall)
            @(posedge clk);
    endtask

    task automatic send_text(input string s);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], i == 0, 1'b0);
    endtask

    function automatic logic [7:0] digit_char(input int d);
        if (d < 10)
            return 8'(CH_ZERO + d);
        return 8'(($urandom_range(1, 0) ? CH_LOWER_A : CH_UPPER_A) + d - 10);
    endfunction

    function automatic logic [7:0] pick_term();
        case ($urandom_range(7, 0))
            0:       return CH_SPACE;
            1:       return CH_TAB;
            2:       return CH_CR;
            3:       return CH_LF;
            4:       return CH_HASH;
            5:       return CH_COMMA;
            6:       return CH_RBRACKET;
            default: return CH_RBRACE;
        endcase
    endfunction

    task automatic push_sign();
        case ($urandom_range(3, 0))
            0:       lit_chars.push_back(CH_PLUS);
            1:       lit_chars.push_back(CH_MINUS);
            default: ;
        endcase
    endtask

    // Digits of the given base with the odd underscore between them; no leading zero in decimal.
    task automatic push_digits(input int base, input int count);
        int d;
        for (int i = 0; i < count; i++)
        begin
            if (i > 0 && $urandom_range(9, 0) == 0)
                lit_chars.push_back(CH_UNDERSCORE);
            d = $urandom_range(base - 1, 0);
            if (i == 0 && base == 10 && count > 1 && d == 0)
                d = 1 + $urandom_range(8, 0);
            lit_chars.push_back(digit_char(d));
        end
    endtask

    task automatic build_literal(output bit by_eoi);
        int         kind;
        int         pos;
        bit         big;
        logic [7:0] mark;
        lit_chars.delete();
        by_eoi = ($urandom_range(19, 0) == 0);
        big    = ($urandom_range(7, 0) == 0);
        kind   = $urandom_range(99, 0);
        if (kind < 30)
        begin
            push_sign();
            if ($urandom_range(9, 0) == 0)
                lit_chars.push_back(CH_ZERO);
            else
                push_digits(10, big ? $urandom_range(23, 17) : $urandom_range(6, 1));
        end
        else if (kind < 50)
        begin
            lit_chars.push_back(CH_ZERO);
            case ($urandom_range(2, 0))
                0:
                begin
                    lit_chars.push_back(CH_LOWER_X);
                    push_digits(16, big ? $urandom_range(20, 15) : $urandom_range(6, 1));
                end
                1:
                begin
                    lit_chars.push_back(CH_LOWER_B);
                    push_digits(2, big ? $urandom_range(68, 62) : $urandom_range(10, 1));
                end
                default:
                begin
                    lit_chars.push_back(CH_LOWER_O);
                    push_digits(8, big ? $urandom_range(24, 20) : $urandom_range(8, 1));
                end
            endcase
        end
        else if (kind < 58)
        begin
            push_sign();
            if ($urandom_range(1, 0))
            begin
                lit_chars.push_back(CH_LOWER_I);
                lit_chars.push_back(CH_LOWER_N);
                lit_chars.push_back(CH_LOWER_F);
            end
            else
            begin
                lit_chars.push_back(CH_LOWER_N);
                lit_chars.push_back(CH_LOWER_A);
                lit_chars.push_back(CH_LOWER_N);
            end
        end
        else if (kind < 68)
        begin
            // Floats and dates: digits with a float, time or date mark, sometimes signed or repeated.
            if ($urandom_range(3, 0) == 0)
                push_sign();
            push_digits(10, $urandom_range(4, 1));
            case ($urandom_range(5, 0))
                0:       mark = CH_DOT;
                1:       mark = CH_LOWER_E;
                2:       mark = CH_UPPER_E;
                3:       mark = CH_UPPER_T;
                4:       mark = CH_COLON;
                default: mark = CH_MINUS;
            endcase
            lit_chars.push_back(mark);
            push_digits(10, $urandom_range(3, 1));
            if ($urandom_range(1, 0))
            begin
                lit_chars.push_back(mark);
                push_digits(10, $urandom_range(2, 1));
            end
        end
        else
        begin
            if ($urandom_range(1, 0))
            begin
                push_sign();
                push_digits(10, $urandom_range(6, 1));
            end
            else
            begin
                lit_chars.push_back(CH_ZERO);
                case ($urandom_range(2, 0))
                    0:       lit_chars.push_back(CH_LOWER_X);
                    1:       lit_chars.push_back(CH_LOWER_B);
                    default: lit_chars.push_back(CH_LOWER_O);
                endcase
                push_digits(16, $urandom_range(6, 1));
            end
            pos = $urandom_range(lit_chars.size() - 1, 0);
            case ($urandom_range(4, 0))
                0:       lit_chars[pos] = 8'($urandom_range(255, 0));
                1:       lit_chars.insert(pos, CH_UNDERSCORE);
                2:       lit_chars.push_back(CH_UNDERSCORE);
                3:       lit_chars.delete();
                default: lit_chars.insert(pos, 8'($urandom_range(255, 0)));
            endcase
        end
        if (!by_eoi)
            lit_chars.push_back(pick_term());
    endtask

    task automatic send_literal(input bit by_eoi);
        // A rare start in mid-literal checks that the state is cleared for a new one.
        foreach (lit_chars[i])
            send_word(lit_chars[i], (i == 0) || ($urandom_range(199, 0) == 0), 1'b0);
        if (by_eoi)
            send_word(8'($urandom_range(255, 0)), lit_chars.size() == 0, 1'b1);
        chars_sent += lit_chars.size() + by_eoi;
    endtask

    task automatic send_noise();
        repeat ($urandom_range(3, 1))
            send_word(8'($urandom_range(255, 0)), 1'b0, $urandom_range(7, 0) == 0);
    endtask

    initial
    begin : stimulus
        bit by_eoi;
        bit hold_done;
        hold_done = 1'b0;
        repeat (3)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_text("0xFf_1 ");
        send_text("-00,");
        send_text("12.");
        send_text("inf");
        send_text("+nax");
        send_word(CH_NUL, 1'b1, 1'b1);
        send_word(8'hFF, 1'b0, 1'b0);
        send_word(CH_NUL, 1'b0, 1'b0);
        send_word(8'hFF, 1'b0, 1'b1);
        send_word(CH_RBRACKET, 1'b1, 1'b0);

        for (int p = 0; p < 4; p++)
        begin
            case (p)
                0:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1:
                begin
                    send_idle_pct  = 76;
                    recv_stall_pct = 0;
                end
                2:
                begin
                    send_idle_pct  = 0;
                    recv_stall_pct = 76;
                end
                default:
                begin
                    send_idle_pct  = 11;
                    recv_stall_pct = 11;
                end
            endcase
            chars_sent = 0;
            while (chars_sent < ITEMS_PER_PHASE)
            begin
                if (p == 0 && !hold_done && chars_sent > 150)
                begin
                    hold_req  = 1'b1;
                    hold_done = 1'b1;
                end
                if ($urandom_range(9, 0) == 0)
                    send_noise();
                build_literal(by_eoi);
                send_literal(by_eoi);
            end
        end

        char_valid <= 1'b0;
        recv_stall_pct = 0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES)
            @(posedge clk);
        if (fail_count == 0 && pending == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
